// ----- rtl/gntc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gntc_pkg: shared types and codes for the neighbour type counter
// Controller state, command/status bundles, item kinds, register indexes.
// ----------------------------------------------------------------------------
package gntc_pkg;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic CFG_MAP_WIDTH  = 1'b0;
	localparam logic CFG_MAP_HEIGHT = 1'b1;

	localparam logic [6:0] MAP_SIZE_RESET = 7'd64;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_ACC,
		ST_DONE
	} gntc_state_t;

	typedef struct packed {
		logic clear;   // zero one store entry, advance the sweep address
		logic load;    // capture the accepted item
		logic write;   // store the captured type code
		logic scan;    // read one window position, advance the window walk
	} gntc_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic scan_last;
	} gntc_sts_t;

endpackage
`default_nettype wire

// ----- rtl/gntc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gntc_ctrl: sequencer for the neighbour type counter
// Runs the clearing sweep, item writes and the window scan of a query.
// ----------------------------------------------------------------------------
module gntc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              kind,
	input  wire gntc_pkg::gntc_sts_t sts,
	output gntc_pkg::gntc_cmd_t    cmd,
	output logic                   busy,
	output logic                   done
);
	import gntc_pkg::*;

	gntc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		busy      = 1'b1;
		done      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (kind == KIND_QUERY) ? ST_SCAN : ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) state_d = ST_ACC;
			end
			// last read returns, its compare lands in the count
			ST_ACC: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/gntc_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gntc_dp: datapath of the neighbour type counter
// Cell store, size registers, window walk counters and the match counter.
// ----------------------------------------------------------------------------
module gntc_dp #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_RADIUS = 7,
	parameter int TYPE_BITS  = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gntc_pkg::gntc_cmd_t cmd,
	output gntc_pkg::gntc_sts_t      sts,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_index,
	input  wire logic [6:0]          cfg_data,
	input  wire logic [5:0]          center_x,
	input  wire logic [5:0]          center_y,
	input  wire logic [7:0]          cell_type,
	input  wire logic [2:0]          radius,
	input  wire logic                cross_only,
	output logic [7:0]               match_count
);
	import gntc_pkg::*;

	localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int XW     = $clog2(MAX_WIDTH);
	localparam int YW     = $clog2(MAX_HEIGHT);
	localparam int MAX_WH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	// signed coordinate: holds -MAX_RADIUS .. 63+MAX_RADIUS and the grid size
	localparam int CW     = $clog2(MAX_WH + 64 + MAX_RADIUS) + 2;
	localparam int CMP_W  = (TYPE_BITS > 8) ? TYPE_BITS : 8;

	localparam logic signed [CW-1:0] RMAX = CW'(MAX_RADIUS);
	localparam logic signed [CW-1:0] WMAX = CW'(MAX_WIDTH);
	localparam logic signed [CW-1:0] HMAX = CW'(MAX_HEIGHT);
	localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(CELLS - 1);

	logic [TYPE_BITS-1:0] mem [CELLS];
	logic [TYPE_BITS-1:0] rd_data_s1;
	logic                 use_s1;

	logic [6:0]            map_width_q, map_height_q;
	logic [ADDR_W-1:0]     clr_addr_q;
	logic signed [CW-1:0]  cx_q, cy_q, x_q, y_q, ys_q, xe_q, ye_q;
	logic [7:0]            want_q;
	logic                  cross_q;
	logic [7:0]            count_q;

	logic signed [CW-1:0]  w_use, h_use, mw_ext, mh_ext;
	logic signed [CW-1:0]  r_in, r_eff, cx_in, cy_in;
	logic                  in_win, wr_ok, mem_we, hit;
	logic [ADDR_W-1:0]     rd_addr, wr_addr, mem_wa;
	logic [TYPE_BITS-1:0]  mem_wd;

	// size above the maximum is taken as the maximum
	assign mw_ext = CW'(map_width_q);
	assign mh_ext = CW'(map_height_q);
	assign w_use  = (mw_ext > WMAX) ? WMAX : mw_ext;
	assign h_use  = (mh_ext > HMAX) ? HMAX : mh_ext;

	assign r_in  = CW'(radius);
	assign r_eff = (r_in > RMAX) ? RMAX : r_in;
	assign cx_in = CW'(center_x);
	assign cy_in = CW'(center_y);

	// current window position: on grid, not the center, cross rule
	assign in_win = (x_q >= 0) && (y_q >= 0) && (x_q < w_use) && (y_q < h_use)
		&& !((x_q == cx_q) && (y_q == cy_q))
		&& !(cross_q && (x_q != cx_q) && (y_q != cy_q));

	assign rd_addr = ADDR_W'(y_q[YW-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_q[XW-1:0]);
	assign wr_addr = ADDR_W'(cy_q[YW-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx_q[XW-1:0]);
	assign wr_ok   = (cx_q < w_use) && (cy_q < h_use);

	assign mem_we = cmd.clear | (cmd.write & wr_ok);
	assign mem_wa = cmd.clear ? clr_addr_q : wr_addr;
	assign mem_wd = cmd.clear ? '0 : TYPE_BITS'(want_q);

	assign hit = use_s1 && (CMP_W'(rd_data_s1) == CMP_W'(want_q));

	assign sts.clear_last = (clr_addr_q == LAST_ADDR);
	assign sts.scan_last  = (x_q == xe_q) && (y_q == ye_q);
	assign match_count    = count_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAP_SIZE_RESET;
			map_height_q <= MAP_SIZE_RESET;
			clr_addr_q   <= '0;
			use_s1       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_MAP_WIDTH:  map_width_q  <= cfg_data;
					CFG_MAP_HEIGHT: map_height_q <= cfg_data;
				endcase
			end
			if (cmd.clear) clr_addr_q <= clr_addr_q + ADDR_W'(1);
			use_s1 <= cmd.scan && in_win;
		end
	end

	// item capture and window walk: columns outer, rows inner
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q    <= cx_in;
			cy_q    <= cy_in;
			want_q  <= cell_type;
			cross_q <= cross_only;
			x_q     <= cx_in - r_eff;
			y_q     <= cy_in - r_eff;
			ys_q    <= cy_in - r_eff;
			xe_q    <= cx_in + r_eff;
			ye_q    <= cy_in + r_eff;
		end else if (cmd.scan) begin
			if (y_q == ye_q) begin
				y_q <= ys_q;
				x_q <= x_q + CW'(1);
			end else begin
				y_q <= y_q + CW'(1);
			end
		end
	end

	// saturating match count
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			count_q <= '0;
		end else if (hit && (count_q != 8'hFF)) begin
			count_q <= count_q + 8'd1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/grid_neighbour_type_count.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grid_neighbour_type_count: type counter over a square cell neighbourhood
//
// A grid of type codes, MAX_WIDTH x MAX_HEIGHT, of which map_width columns
// and map_height rows are in use. Items are taken at a clock edge with start
// high and busy low. kind write stores cell_type at (center_x, center_y) when
// that cell lies in the map in use, and gives no result. kind query walks
// the window of half width r = min(radius, MAX_RADIUS) one position per cycle
// through the single store read port, then done strobes for one cycle with
// match_count; the next item can be taken once busy is low again.
// The result cannot be held off; match_count keeps it until the next item.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 = map_width,
// 1 = map_height; cfg_ready is always high. Write it only while idle.
// Reset: sizes go to 64, then a clearing pass zeroes the store one entry per
// cycle, all MAX_WIDTH*MAX_HEIGHT entries (4096 by default), with busy high.
// ----------------------------------------------------------------------------
module grid_neighbour_type_count #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_RADIUS = 7,
	parameter int TYPE_BITS  = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic       kind,
	input  wire logic [5:0] center_x,
	input  wire logic [5:0] center_y,
	input  wire logic [7:0] cell_type,
	input  wire logic [2:0] radius,
	input  wire logic       cross_only,
	output logic            done,
	output logic [7:0]      match_count,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [6:0] cfg_data
);
	import gntc_pkg::*;

	gntc_cmd_t cmd;
	gntc_sts_t sts;

	assign cfg_ready = 1'b1;

	gntc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gntc_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_RADIUS (MAX_RADIUS),
		.TYPE_BITS  (TYPE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid & cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.center_x    (center_x),
		.center_y    (center_y),
		.cell_type   (cell_type),
		.radius      (radius),
		.cross_only  (cross_only),
		.match_count (match_count)
	);

endmodule
`default_nettype wire

// ----- rtl/gntc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gntc_checker: port-level checks for the neighbour type counter
// Result strobe against busy, and the no-result rule of a write transfer.
// ----------------------------------------------------------------------------
module gntc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic kind,
	input wire logic done
);
	import gntc_pkg::*;

	// a result only comes while the item is still in work
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// block is free right after a result
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done))
		else $error("block not free after result");

	// an accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after accepted transfer");

	// a write transfer gives no result
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == KIND_WRITE)) |=> !done ##1 !done)
		else $error("result after write transfer");

endmodule

bind grid_neighbour_type_count gntc_checker u_gntc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.kind   (kind),
	.done   (done)
);
`default_nettype wire
